// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame checker's checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, sampled on the rising clock and disabled during reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication, sampled on the rising clock and disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

// ===== hdl/mfc_pkg.sv =====
// ----------------------------------------------------------------------------
// mfc_pkg
// Types and constants shared by the message frame checker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mfc_pkg;

	// Framing modes.
	typedef logic [2:0] mode_t;
	localparam mode_t MODE_LF   = 3'd0;
	localparam mode_t MODE_CRLF = 3'd1;
	localparam mode_t MODE_LE32 = 3'd2;
	localparam mode_t MODE_LE64 = 3'd3;
	localparam mode_t MODE_BE32 = 3'd4;
	localparam mode_t MODE_BE64 = 3'd5;

	// Result status codes.
	typedef logic [2:0] status_t;
	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_SHORT     = 3'd1;
	localparam status_t ST_TOO_LARGE = 3'd2;
	localparam status_t ST_TRAILING  = 3'd3;
	localparam status_t ST_RANGE     = 3'd4;

	// Configuration register indexes.
	typedef logic [1:0] reg_index_t;
	localparam reg_index_t REG_FRAME_MODE = 2'd0;
	localparam reg_index_t REG_STRIP      = 2'd1;
	localparam reg_index_t REG_MAX_FRAME  = 2'd2;

	// Characters and prefix sizes.
	localparam logic [7:0] CHR_CR = 8'h0D;
	localparam logic [7:0] CHR_LF = 8'h0A;
	localparam logic [3:0] PSIZE_SHORT = 4'd4;
	localparam logic [3:0] PSIZE_LONG  = 4'd8;

	// Field widths of one result.
	localparam int STATUS_W = 3;
	localparam int OFFSET_W = 4;
	localparam int FLEN_W   = 32;
	localparam int MAXF_W   = 32;

	// Configuration as seen by the tracker.
	typedef struct packed {
		mode_t             mode;
		logic              strip;
		logic [MAXF_W-1:0] max_frame;
	} cfg_t;

	// One input item.
	typedef struct packed {
		logic [7:0] data;
		logic       bvalid;
		logic       last;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [FLEN_W-1:0]   length;
		logic [OFFSET_W-1:0] offset;
		status_t             status;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/mfc_track.sv =====
// ----------------------------------------------------------------------------
// mfc_track
// Per-message state: byte counter, delimiter search and prefix assembly,
// plus the end-of-message evaluation of status, offset and length.
// ----------------------------------------------------------------------------
`default_nettype none

module mfc_track #(
	parameter int LENGTH_BITS = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mfc_pkg::cfg_t   cfg,
	input  wire mfc_pkg::item_t  item,
	input  wire logic            take,
	output mfc_pkg::result_t     result
);

	// Counter width; the ceiling is all ones at this width.
	localparam int CW = (LENGTH_BITS > 32) ? 32 : LENGTH_BITS;
	localparam int LW = CW + 2;
	localparam int PW = CW + 1;

	logic [CW-1:0] cnt_q, pos_q;
	logic          found_q, prev_cr_q;
	logic [63:0]   prefix_q;

	logic [CW-1:0] cnt_nx, pos_nx;
	logic          found_nx, prev_cr_nx;
	logic [63:0]   prefix_nx;

	mfc_pkg::mode_t mode;
	logic           long_prefix;
	logic [3:0]     psize;
	logic [1:0]     dlen;
	logic [LW-1:0]  sum_pd, flen_line;
	logic [PW-1:0]  sum_pl;
	logic           no_limit;

	// Next state after the current byte.
	always_comb begin
		mode = (cfg.mode > mfc_pkg::MODE_BE64) ? mfc_pkg::MODE_LF : cfg.mode;
		long_prefix = (mode == mfc_pkg::MODE_LE64) || (mode == mfc_pkg::MODE_BE64);
		psize = long_prefix ? mfc_pkg::PSIZE_LONG : mfc_pkg::PSIZE_SHORT;

		cnt_nx     = cnt_q;
		pos_nx     = pos_q;
		found_nx   = found_q;
		prev_cr_nx = prev_cr_q;
		prefix_nx  = prefix_q;

		if (item.bvalid) begin
			priority if (mode == mfc_pkg::MODE_LF) begin
				if (!found_q && item.data == mfc_pkg::CHR_LF) begin
					found_nx = 1'b1;
					pos_nx   = cnt_q;
				end
			end else if (mode == mfc_pkg::MODE_CRLF) begin
				if (!found_q && prev_cr_q && item.data == mfc_pkg::CHR_LF) begin
					found_nx = 1'b1;
					pos_nx   = cnt_q - CW'(1);
				end
				prev_cr_nx = (item.data == mfc_pkg::CHR_CR);
			end else begin
				if (cnt_q < CW'(psize)) begin
					if (mode == mfc_pkg::MODE_LE32 || mode == mfc_pkg::MODE_LE64) begin
						prefix_nx = prefix_q | (64'(item.data) << {cnt_q[2:0], 3'b000});
					end else begin
						prefix_nx = {prefix_q[55:0], item.data};
					end
				end
			end
			// The counter holds at its ceiling.
			if (!(&cnt_q)) begin
				cnt_nx = cnt_q + CW'(1);
			end
		end
	end

	// End-of-message evaluation on the updated state.
	always_comb begin
		dlen      = (mode == mfc_pkg::MODE_CRLF) ? 2'd2 : 2'd1;
		sum_pd    = LW'(pos_nx) + LW'(dlen);
		flen_line = cfg.strip ? LW'(pos_nx) : sum_pd;
		sum_pl    = PW'(prefix_nx[CW-1:0]) + PW'(psize);
		no_limit  = (cfg.max_frame == '0);

		result.status = mfc_pkg::ST_OK;
		result.offset = '0;
		result.length = '0;

		if (mode == mfc_pkg::MODE_LF || mode == mfc_pkg::MODE_CRLF) begin
			priority if (!found_nx) begin
				result.status = mfc_pkg::ST_SHORT;
			end else if (flen_line[LW-1:CW] != '0 ||
				(!no_limit && 64'(flen_line) > 64'(cfg.max_frame))) begin
				result.status = mfc_pkg::ST_TOO_LARGE;
			end else if (LW'(cnt_nx) > sum_pd) begin
				result.status = mfc_pkg::ST_TRAILING;
			end else begin
				result.length = mfc_pkg::FLEN_W'(flen_line);
			end
		end else begin
			result.offset = psize;
			priority if (cnt_nx < CW'(psize)) begin
				result.status = mfc_pkg::ST_SHORT;
			end else if (prefix_nx[63:CW] != '0) begin
				result.status = mfc_pkg::ST_RANGE;
			end else if (!no_limit && prefix_nx > 64'(cfg.max_frame)) begin
				result.status = mfc_pkg::ST_TOO_LARGE;
			end else if (PW'(cnt_nx) < sum_pl) begin
				result.status = mfc_pkg::ST_SHORT;
			end else if (PW'(cnt_nx) > sum_pl) begin
				result.status = mfc_pkg::ST_TRAILING;
			end else begin
				result.length = mfc_pkg::FLEN_W'(prefix_nx[CW-1:0]);
			end
		end
	end

	// State registers; a message end clears them for the next message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			pos_q     <= '0;
			found_q   <= 1'b0;
			prev_cr_q <= 1'b0;
			prefix_q  <= '0;
		end else if (take) begin
			if (item.last) begin
				cnt_q     <= '0;
				pos_q     <= '0;
				found_q   <= 1'b0;
				prev_cr_q <= 1'b0;
				prefix_q  <= '0;
			end else begin
				cnt_q     <= cnt_nx;
				pos_q     <= pos_nx;
				found_q   <= found_nx;
				prev_cr_q <= prev_cr_nx;
				prefix_q  <= prefix_nx;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/message_frame_checker.sv =====
// ----------------------------------------------------------------------------
// message_frame_checker
// Checks that a byte-stream message holds exactly one line-delimited or
// length-prefixed frame and reports status, frame offset and frame length.
// ----------------------------------------------------------------------------
//
//   channel  direction  transaction contents
//   s_*      in         one message byte (tdata), byte present (tuser), end (tlast)
//   m_*      out        one result per message end: status, offset, length
//   cfg_*    in         register write, index 0 mode, 1 strip, 2 max frame size
//
// One byte is taken every cycle while the input is not stalled; a result is valid
// once the byte that ends its message has sat in the input register and its
// verdict has been loaded into the result register.
// Reset clears the configuration to its defaults and all message state.
// A waiting result stalls the input only when the next queued byte also ends
// a message; other bytes keep flowing.
//
`default_nettype none

module message_frame_checker #(
	parameter int LENGTH_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tuser,   // [0] byte_valid
	input  wire logic        s_tlast,   // last_byte
	// Result stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [2:0] status, [6:3] frame_offset,
	                                    // [38:7] frame_length, [39] zero
	// Configuration writes.
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	mfc_pkg::cfg_t    cfg_q;
	mfc_pkg::item_t   item_s1;
	logic             valid_s1;
	logic             advance;
	mfc_pkg::result_t result;
	mfc_pkg::result_t out_s2;
	logic             out_valid_s2;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= mfc_pkg::MODE_LF;
			cfg_q.strip     <= 1'b1;
			cfg_q.max_frame <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mfc_pkg::REG_FRAME_MODE: cfg_q.mode      <= cfg_data[2:0];
				mfc_pkg::REG_STRIP:      cfg_q.strip     <= cfg_data[0];
				mfc_pkg::REG_MAX_FRAME:  cfg_q.max_frame <= cfg_data;
				default: ;
			endcase
		end
	end

	// The input stage moves on unless it ends a message and the result is stuck.
	assign advance  = !item_s1.last || !out_valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.data   <= s_tdata;
			item_s1.bvalid <= s_tuser;
			item_s1.last   <= s_tlast;
		end
	end

	// Message state and evaluation.
	mfc_track #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (item_s1),
		.take   (valid_s1 && advance),
		.result (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (valid_s1 && advance && item_s1.last) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance && item_s1.last) begin
			out_s2 <= result;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {1'b0, out_s2.length, out_s2.offset, out_s2.status};

endmodule

`default_nettype wire

// ===== hdl/mfc_checker.sv =====
// ----------------------------------------------------------------------------
// mfc_checker
// Port-level checks on the frame checker's result stream, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mfc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tlast,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata
);

	mfc_pkg::status_t status;
	logic [3:0]       offset;
	logic [31:0]      length;
	logic             m_stall;
	logic             failed;
	logic             offset_ok;
	logic             s_end;

	assign status    = m_tdata[2:0];
	assign offset    = m_tdata[6:3];
	assign length    = m_tdata[38:7];
	assign m_stall   = m_tvalid && !m_tready;
	assign failed    = m_tvalid && (status != mfc_pkg::ST_OK);
	assign offset_ok = (offset == '0) || (offset == mfc_pkg::PSIZE_SHORT) ||
		(offset == mfc_pkg::PSIZE_LONG);
	assign s_end     = s_tvalid && s_tready && s_tlast;

	// A stalled result holds.
	`ASSERT_CLK(a_hold, clk, arst_n, m_stall |=> m_tvalid && $stable(m_tdata), "result changed")

	// A failed check reports no length.
	`ASSERT_IMPLY(a_len_zero, clk, arst_n, failed, length == '0 && !m_tdata[39], "bad length")

	// The offset is zero or one of the two prefix sizes.
	`ASSERT_IMPLY(a_offset, clk, arst_n, m_tvalid, offset_ok, "bad frame offset")

	// A new result follows an earlier message end on the input.
	`ASSERT_IMPLY(a_cause, clk, arst_n, $rose(m_tvalid), $past(s_end, 2), "result with no end")

endmodule

bind message_frame_checker mfc_checker u_mfc_checker (.*);

`default_nettype wire

// ===== verif/message_frame_checker_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// message_frame_checker_monitor
// Watches the byte, result and register channels of the frame checker. It
// keeps its own copy of the registers and the per-message state, works out
// the result for every message end, and compares each result transaction
// field by field with the oldest one still owed.
// ----------------------------------------------------------------------------

module message_frame_checker_monitor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tuser,   // [0] byte_valid
	input  wire logic        s_tlast,   // last_byte
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [39:0] m_tdata,   // [2:0] status, [6:3] frame_offset,
	                                    // [38:7] frame_length, [39] zero
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output int               error_count,
	output int               results_pending
);

	// Byte counter ceiling for a 32-bit counter.
	localparam logic [63:0] COUNT_CEIL = 64'h0000_0000_FFFF_FFFF;

	// Register copies.
	mfc_pkg::mode_t             cur_mode;
	logic                       cur_strip;
	logic [mfc_pkg::MAXF_W-1:0] cur_max_frame;

	// State of the message in progress.
	logic [31:0] seen_bytes;
	logic        delim_seen;
	logic [31:0] delim_at;
	logic        last_was_cr;
	logic [63:0] length_prefix;

	mfc_pkg::result_t owed_results[$];
	int               mismatches;

	// Unused mode codes fall back to LF lines.
	function automatic mfc_pkg::mode_t active_mode();
		return (cur_mode > mfc_pkg::MODE_BE64) ? mfc_pkg::MODE_LF : cur_mode;
	endfunction

	function automatic logic [3:0] prefix_bytes(input mfc_pkg::mode_t m);
		return (m == mfc_pkg::MODE_LE64 || m == mfc_pkg::MODE_BE64) ?
			mfc_pkg::PSIZE_LONG : mfc_pkg::PSIZE_SHORT;
	endfunction

	task automatic clear_message();
		seen_bytes    = '0;
		delim_seen    = 1'b0;
		delim_at      = '0;
		last_was_cr   = 1'b0;
		length_prefix = '0;
	endtask

	// Fold one message byte into the delimiter search or the prefix.
	task automatic absorb_byte(input logic [7:0] b);
		mfc_pkg::mode_t m;
		m = active_mode();
		case (m)
			mfc_pkg::MODE_LF: begin
				if (!delim_seen && b == mfc_pkg::CHR_LF) begin
					delim_seen = 1'b1;
					delim_at   = seen_bytes;
				end
			end
			mfc_pkg::MODE_CRLF: begin
				if (!delim_seen && last_was_cr && b == mfc_pkg::CHR_LF) begin
					delim_seen = 1'b1;
					delim_at   = seen_bytes - 32'd1;
				end
				last_was_cr = (b == mfc_pkg::CHR_CR);
			end
			default: begin
				if (seen_bytes < 32'(prefix_bytes(m))) begin
					if (m == mfc_pkg::MODE_LE32 || m == mfc_pkg::MODE_LE64)
						length_prefix = length_prefix | (64'(b) << (seen_bytes * 8));
					else
						length_prefix = {length_prefix[55:0], b};
				end
			end
		endcase
		if (64'(seen_bytes) < COUNT_CEIL)
			seen_bytes = seen_bytes + 32'd1;
	endtask

	// Status, offset and length owed at the end of the current message.
	function automatic mfc_pkg::result_t frame_verdict();
		mfc_pkg::result_t r;
		mfc_pkg::mode_t   m;
		logic [63:0]      total, flen, dlen, psize, limit;
		m        = active_mode();
		total    = 64'(seen_bytes);
		limit    = 64'(cur_max_frame);
		r.status = mfc_pkg::ST_OK;
		r.offset = '0;
		flen     = '0;
		if (m == mfc_pkg::MODE_LF || m == mfc_pkg::MODE_CRLF) begin
			dlen = (m == mfc_pkg::MODE_CRLF) ? 64'd2 : 64'd1;
			if (!delim_seen) begin
				r.status = mfc_pkg::ST_SHORT;
			end else begin
				flen = cur_strip ? 64'(delim_at) : 64'(delim_at) + dlen;
				if (flen > COUNT_CEIL || (limit != 0 && flen > limit))
					r.status = mfc_pkg::ST_TOO_LARGE;
				else if (total > 64'(delim_at) + dlen)
					r.status = mfc_pkg::ST_TRAILING;
			end
		end else begin
			r.offset = prefix_bytes(m);
			psize    = 64'(r.offset);
			flen     = length_prefix;
			if (total < psize)
				r.status = mfc_pkg::ST_SHORT;
			else if (flen > COUNT_CEIL)
				r.status = mfc_pkg::ST_RANGE;
			else if (limit != 0 && flen > limit)
				r.status = mfc_pkg::ST_TOO_LARGE;
			else if (total < psize + flen)
				r.status = mfc_pkg::ST_SHORT;
			else if (total > psize + flen)
				r.status = mfc_pkg::ST_TRAILING;
		end
		r.length = (r.status == mfc_pkg::ST_OK) ? flen[mfc_pkg::FLEN_W-1:0] : '0;
		return r;
	endfunction

	// Track every channel on the rising clock.
	always @(posedge clk or negedge arst_n) begin
		mfc_pkg::result_t want, got;
		if (!arst_n) begin
			cur_mode      = mfc_pkg::MODE_LF;
			cur_strip     = 1'b1;
			cur_max_frame = '0;
			clear_message();
			owed_results.delete();
			mismatches       = 0;
			error_count     <= 0;
			results_pending <= 0;
		end else begin
			// Result transaction: compare with the oldest owed result.
			if (m_tvalid && m_tready) begin
				got = mfc_pkg::result_t'(m_tdata[38:0]);
				if (owed_results.size() == 0) begin
					mismatches++;
					$display("%0t: result with none owed, expected nothing, got %h",
						$time, m_tdata);
				end else begin
					want = owed_results.pop_front();
					if (got.status !== want.status) begin
						mismatches++;
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, want.status, got.status);
					end
					if (got.offset !== want.offset) begin
						mismatches++;
						$display("%0t: frame_offset mismatch, expected %0d, got %0d",
							$time, want.offset, got.offset);
					end
					if (got.length !== want.length) begin
						mismatches++;
						$display("%0t: frame_length mismatch, expected %0d, got %0d",
							$time, want.length, got.length);
					end
				end
				if (m_tdata[39] !== 1'b0) begin
					mismatches++;
					$display("%0t: padding bit mismatch, expected 0, got %b",
						$time, m_tdata[39]);
				end
			end

			// Register writes.
			if (cfg_we) begin
				case (mfc_pkg::reg_index_t'(cfg_index))
					mfc_pkg::REG_FRAME_MODE: cur_mode      = mfc_pkg::mode_t'(cfg_data[2:0]);
					mfc_pkg::REG_STRIP:      cur_strip     = cfg_data[0];
					mfc_pkg::REG_MAX_FRAME:  cur_max_frame = cfg_data;
					default: ;
				endcase
			end

			// Byte transaction: update the message and close it on the end mark.
			if (s_tvalid && s_tready) begin
				if (s_tuser)
					absorb_byte(s_tdata);
				if (s_tlast) begin
					owed_results.push_back(frame_verdict());
					clear_message();
				end
			end

			error_count     <= mismatches;
			results_pending <= owed_results.size();
		end
	end

endmodule

// ===== verif/message_frame_checker_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// message_frame_checker_tb
// Drives messages in every framing mode through the frame checker: a short
// directed set, then random phases, each under its own register setting,
// with random gaps on the byte and result channels and one long result
// hold-off. The monitor predicts and checks every result.
// ----------------------------------------------------------------------------

module message_frame_checker_tb;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_COUNT   = 16;
	localparam int PHASE_ITEMS   = 75;
	localparam int SETTLE_CYCLES = 4;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tuser;   // [0] byte_valid
	logic        s_tlast;   // last_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [2:0] status, [6:3] frame_offset, [38:7] frame_length
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	int          error_count;
	int          results_pending;
	int unsigned cycle_count = 0;

	// Stimulus controls; rx_idle_pct and hold_trigger are shared with the result-side process.
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	bit          hold_trigger = 1'b0;
	int          items_sent = 0;
	logic [7:0]  frame_bytes[$];

	message_frame_checker uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	message_frame_checker_monitor monitor (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.error_count     (error_count),
		.results_pending (results_pending)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[message_frame_checker] ERROR");
			$finish;
		end
	end

	// Gap length: none unless a draw falls under pct, then mostly short and now and then long.
	function automatic int pick_gap(input int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(40, 12);
		return $urandom_range(3, 1);
	endfunction

	function automatic int pick_length();
		if ($urandom_range(99) < 90)
			return $urandom_range(8);
		return $urandom_range(40, 9);
	endfunction

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		int stall;
		bit hold_done;
		hold_done = 1'b0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_trigger && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = pick_gap(rx_idle_pct);
				if (stall != 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end else begin
					m_tready <= 1'b1;
					repeat ($urandom_range(8, 1)) @(posedge clk);
				end
			end
		end
	end

	// Offer one byte transaction and return at the edge that takes it.
	task automatic put_item(input logic [7:0] d, input logic bv, input logic lst);
		int gap;
		gap = pick_gap(tx_idle_pct);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= bv;
		s_tlast  <= lst;
		do
			@(negedge clk);
		while (!s_tready);
		@(posedge clk);
		items_sent++;
	endtask

	// Send frame_bytes as one message, with stray empty bytes sprinkled in.
	task automatic send_message(input bit separate_end);
		int i;
		for (i = 0; i < frame_bytes.size(); i++) begin
			if ($urandom_range(29) == 0)
				put_item(8'($urandom), 1'b0, 1'b0);
			put_item(frame_bytes[i], 1'b1, !separate_end && i == frame_bytes.size() - 1);
		end
		if (separate_end || frame_bytes.size() == 0)
			put_item(8'($urandom), 1'b0, 1'b1);
	endtask

	// Stop offering, wait for every owed result, then let the pipeline settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all three registers on consecutive edges.
	task automatic set_config(input mfc_pkg::mode_t m, input logic strip,
		input logic [31:0] max_frame);
		cfg_we    <= 1'b1;
		cfg_index <= mfc_pkg::REG_FRAME_MODE;
		cfg_data  <= 32'(m);
		@(posedge clk);
		cfg_index <= mfc_pkg::REG_STRIP;
		cfg_data  <= 32'(strip);
		@(posedge clk);
		cfg_index <= mfc_pkg::REG_MAX_FRAME;
		cfg_data  <= max_frame;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Line message: mostly payload plus delimiter, sometimes trailing bytes
	// or no delimiter appended at all.
	task automatic build_line(input bit crlf);
		int         n, i, kind;
		bit         clean;
		logic [7:0] b, prev;
		frame_bytes.delete();
		n     = pick_length();
		kind  = $urandom_range(9);
		clean = (kind < 7);
		prev  = 8'h00;
		for (i = 0; i < n; i++) begin
			case ($urandom_range(7))
				0: b = mfc_pkg::CHR_CR;
				1: b = mfc_pkg::CHR_LF;
				default: b = 8'($urandom);
			endcase
			if (clean && b == mfc_pkg::CHR_LF && (!crlf || prev == mfc_pkg::CHR_CR))
				b = 8'h2E;
			frame_bytes.push_back(b);
			prev = b;
		end
		if (clean) begin
			if (crlf)
				frame_bytes.push_back(mfc_pkg::CHR_CR);
			frame_bytes.push_back(mfc_pkg::CHR_LF);
			if (kind == 6)
				repeat ($urandom_range(3, 1)) frame_bytes.push_back(8'($urandom));
		end
	endtask

	// Length-prefixed message: mostly well formed, the rest with a short body,
	// extra bytes, a cut prefix or an oversized length.
	task automatic build_prefixed(input mfc_pkg::mode_t m);
		int          psize, nprefix, len, body_n, kind, i;
		bit          little;
		logic [63:0] value;
		frame_bytes.delete();
		psize   = (m == mfc_pkg::MODE_LE64 || m == mfc_pkg::MODE_BE64) ?
			int'(mfc_pkg::PSIZE_LONG) : int'(mfc_pkg::PSIZE_SHORT);
		little  = (m == mfc_pkg::MODE_LE32 || m == mfc_pkg::MODE_LE64);
		kind    = $urandom_range(19);
		len     = pick_length();
		value   = 64'(len);
		body_n  = len;
		nprefix = psize;
		case (kind)
			14: if (len > 0) body_n = len - $urandom_range(len, 1);
			15: body_n = len + $urandom_range(3, 1);
			16: begin
				nprefix = $urandom_range(psize - 1);
				body_n  = 0;
			end
			17: value = {$urandom, $urandom};
			18: value = 64'h0000_0000_FFFF_FFFF;
			19: value = 64'h0000_0001_0000_0000 + 64'(len);
			default: ;
		endcase
		if (psize == int'(mfc_pkg::PSIZE_SHORT))
			value[63:32] = '0;
		for (i = 0; i < nprefix; i++)
			frame_bytes.push_back(little ? value[8*i +: 8] : value[8*(psize-1-i) +: 8]);
		for (i = 0; i < body_n; i++)
			frame_bytes.push_back(8'($urandom));
	endtask

	task automatic build_frame(input mfc_pkg::mode_t m);
		if (m == mfc_pkg::MODE_CRLF)
			build_line(1'b1);
		else if (m == mfc_pkg::MODE_LF || m > mfc_pkg::MODE_BE64)
			build_line(1'b0);
		else
			build_prefixed(m);
	endtask

	// Main stimulus.
	initial begin
		int             p, phase_end;
		mfc_pkg::mode_t m;
		logic           strip;
		logic [31:0]    max_frame;

		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= 1'b0;
		s_tlast   <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= mfc_pkg::REG_FRAME_MODE;
		cfg_data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset setting (LF lines, stripped, no limit).
		frame_bytes.delete();
		send_message(1'b0);                       // empty message
		frame_bytes = '{8'h00, 8'hFF, mfc_pkg::CHR_LF};
		send_message(1'b0);                       // extreme bytes, then LF
		frame_bytes = '{mfc_pkg::CHR_LF, 8'h7E};
		send_message(1'b0);                       // byte after the delimiter
		put_item(8'hFF, 1'b0, 1'b0);              // empty byte with no end
		frame_bytes = '{8'h55, 8'hAA};
		send_message(1'b1);                       // no delimiter, separate end
		drain();

		// Directed: big-endian prefix above the counter range.
		set_config(mfc_pkg::MODE_BE64, 1'b0, 32'hFFFF_FFFF);
		frame_bytes = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_message(1'b0);
		drain();

		// Directed: prefix over the frame size limit.
		set_config(mfc_pkg::MODE_LE32, 1'b1, 32'd1);
		frame_bytes = '{8'h02, 8'h00, 8'h00, 8'h00};
		send_message(1'b0);
		drain();

		// Random phases, each under its own register setting.
		for (p = 0; p < PHASE_COUNT; p++) begin
			m     = (p < 8) ? mfc_pkg::mode_t'(p) : mfc_pkg::mode_t'($urandom_range(7));
			strip = (p < 4) ? p[0] : 1'($urandom_range(1));
			case (p % 4)
				0: max_frame = '0;
				1: max_frame = 32'hFFFF_FFFF;
				2: max_frame = $urandom_range(10, 1);
				default: max_frame = $urandom;
			endcase
			set_config(m, strip, max_frame);
			case (p % 3)
				0: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
				1: begin
					tx_idle_pct = 20;
					rx_idle_pct = 20;
				end
				default: begin
					tx_idle_pct = 50;
					rx_idle_pct = 60;
				end
			endcase
			if (p == 5) begin
				tx_idle_pct  = 0;
				hold_trigger = 1'b1;
			end
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				build_frame(m);
				send_message($urandom_range(7) == 0);
			end
			drain();
		end

		if (error_count == 0)
			$display("[message_frame_checker] OK");
		else
			$display("[message_frame_checker] ERROR");
		$finish;
	end

endmodule
